>>> rtl/swm_pkg.sv
`timescale 1ns / 1ps
package swm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int WSIZE_W    = 7;
    localparam int ENTRY_W    = SAMPLE_W + CNT_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register index as seen on paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [CNT_W-1:0]           stamp;
    } t_entry;

endpackage

>>> rtl/swm_if.sv
`timescale 1ns / 1ps
interface swm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::SAMPLE_W-1:0] sample;
    logic                                start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::SAMPLE_W-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

>>> rtl/swm_ram.sv
`timescale 1ns / 1ps
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/swm_cmp.sv
`timescale 1ns / 1ps
module swm_cmp (
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_a,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_b,
    output logic                                o_lt
);

    // signed less-than, shared by the age check and the value check
    assign o_lt = (i_a < i_b);

endmodule

>>> rtl/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
// sliding window maximum, one shared comparator under a sequencer, one sample at a time
// steps per sample: front checks drop expired entries, back checks pop smaller ones, then a push
//   and, once the window has filled, a front read and the result load, which waits on a full result register
// the result beat is offered from a registered output
// reset (synchronous, active low): empty queue, zero sample count, window size 1;
//   the candidate ram is not cleared, only entries below the fill count are ever used
module sliding_window_maximum_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swm_in_if.sink                      i_in,
    swm_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::PADDR_W-1:0] paddr,
    input  logic [swm_pkg::PDATA_W-1:0] pwdata,
    output logic [swm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample beat
    localparam logic [2:0] S_FRD  = 3'd1;  // read queue front
    localparam logic [2:0] S_FCMP = 3'd2;  // front expired? then drop it
    localparam logic [2:0] S_BRD  = 3'd3;  // read queue back
    localparam logic [2:0] S_BCMP = 3'd4;  // back smaller than sample? then pop it
    localparam logic [2:0] S_WR   = 3'd5;  // push sample, fetch front for the result
    localparam logic [2:0] S_RES  = 3'd6;  // load output register

    logic [2:0]                         r_state, n_state;
    logic [swm_pkg::CNT_W-1:0]          r_count, n_count;     // queue fill count
    logic [swm_pkg::IDX_W-1:0]          r_head, n_head;       // queue front in the ring
    logic [swm_pkg::CNT_W-1:0]          r_seen, n_seen;       // saturating sample count
    logic [swm_pkg::CNT_W-1:0]          r_time, n_time;       // arrival stamp counter
    logic [swm_pkg::CNT_W-1:0]          r_cur, n_cur;         // stamp of the sample in work
    logic signed [swm_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                               r_use_s, n_use_s;     // result is the sample itself
    logic [swm_pkg::WSIZE_W-1:0]        r_wsize;
    logic                               r_out_valid, n_out_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_out_data, n_out_data;

    // effective window length, zero treated as one, clipped to the capacity
    logic [swm_pkg::CNT_W-1:0] k_eff;
    always_comb begin
        if (r_wsize == '0) begin
            k_eff = swm_pkg::CNT_W'(1);
        end else if (int'(r_wsize) > swm_pkg::WINDOW_MAX) begin
            k_eff = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end else begin
            k_eff = swm_pkg::CNT_W'(r_wsize);
        end
    end

    // apb register
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = swm_pkg::PDATA_W'(r_wsize);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= swm_pkg::WSIZE_W'(1);
        end else if (cfg_wr && (paddr[2] == swm_pkg::REG_WINDOW_SIZE)) begin
            r_wsize <= pwdata[swm_pkg::WSIZE_W-1:0];
        end
    end

    // candidate queue ram, ring addressed from r_head
    logic                        ram_we, ram_re;
    logic [swm_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
    swm_pkg::t_entry             ram_wdata, ram_rdata;
    logic [swm_pkg::ENTRY_W-1:0] ram_rbits;

    swm_ram #(
        .WIDTH (swm_pkg::ENTRY_W),
        .DEPTH (swm_pkg::WINDOW_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = swm_pkg::t_entry'(ram_rbits);

    // shared comparator: age vs window in S_FCMP, back value vs sample otherwise
    logic [swm_pkg::CNT_W-1:0]           front_age;
    logic signed [swm_pkg::SAMPLE_W-1:0] cmp_a, cmp_b;
    logic                                cmp_lt;

    assign front_age = r_cur - ram_rdata.stamp;  // ages stay below the stamp wrap

    always_comb begin
        if (r_state == S_FCMP) begin
            cmp_a = swm_pkg::SAMPLE_W'(front_age);
            cmp_b = swm_pkg::SAMPLE_W'(k_eff);
        end else begin
            cmp_a = ram_rdata.value;
            cmp_b = r_sample;
        end
    end

    swm_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt)
    );

    logic in_beat, out_free;
    logic [swm_pkg::CNT_W:0]   seen_inc;
    logic [swm_pkg::CNT_W-1:0] seen_base;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign seen_base  = i_in.start_req ? '0 : r_seen;
    assign seen_inc   = {1'b0, seen_base} + (swm_pkg::CNT_W + 1)'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_seen      = r_seen;
        n_time      = r_time;
        n_cur       = r_cur;
        n_sample    = r_sample;
        n_use_s     = r_use_s;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_head + r_count[swm_pkg::IDX_W-1:0];
        ram_raddr   = r_head;
        ram_wdata   = '{value: r_sample, stamp: r_cur};

        // result beat taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_sample = i_in.sample;
                    n_cur    = r_time;
                    n_time   = r_time + swm_pkg::CNT_W'(1);
                    if (i_in.start_req) begin
                        n_count = '0;
                    end
                    // saturate at the window, also clamps after a shrink
                    if (seen_inc > {1'b0, k_eff}) begin
                        n_seen = k_eff;
                    end else begin
                        n_seen = seen_inc[swm_pkg::CNT_W-1:0];
                    end
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                if (r_count == '0) begin
                    n_state = S_BRD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_state   = S_FCMP;
                end
            end
            S_FCMP: begin
                // age >= window: entry has left the window
                if (!cmp_lt) begin
                    n_head  = r_head + swm_pkg::IDX_W'(1);
                    n_count = r_count - swm_pkg::CNT_W'(1);
                    n_state = S_FRD;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                if (r_count == '0) begin
                    n_state = S_WR;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head + r_count[swm_pkg::IDX_W-1:0] - swm_pkg::IDX_W'(1);
                    n_state   = S_BCMP;
                end
            end
            S_BCMP: begin
                // strictly smaller back entry can never be a maximum again
                if (cmp_lt) begin
                    n_count = r_count - swm_pkg::CNT_W'(1);
                    n_state = S_BRD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (int'(r_count) < swm_pkg::WINDOW_MAX) begin
                    ram_we  = 1'b1;
                    n_count = r_count + swm_pkg::CNT_W'(1);
                end
                n_use_s = (r_count == '0);
                if (r_seen == k_eff) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_state   = S_RES;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_use_s ? r_sample : ram_rdata.value;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_seen      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_seen      <= n_seen;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_sample   <= n_sample;
        r_use_s    <= n_use_s;
        r_out_data <= n_out_data;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_max = r_out_data;

endmodule

>>> rtl/swm_checker.sv
`timescale 1ns / 1ps
module swm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [swm_pkg::SAMPLE_W-1:0] i_out_data
);

    // result beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one sample at a time: ready drops right after a sample beat
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while busy");

    // a result never appears the cycle right after a sample beat
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result too early after sample beat");

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.window_max)
);
